// File: hw/rtl/ascon_pkg.sv
`default_nettype none

package ascon_pkg;

    // Default round counts for the two permutation variants.
    localparam int unsigned ROUNDS_FULL  = 12;
    localparam int unsigned ROUNDS_SHORT = 6;

    // Size of the round constant table and the counter that walks it.
    localparam int unsigned NUM_RC = 12;
    localparam int unsigned CNT_W  = 4;

    localparam int unsigned WORD_W = 64;

    // Operation codes.
    localparam logic OP_FULL  = 1'b0;
    localparam logic OP_SHORT = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [4:0][WORD_W-1:0] t_state;

    typedef struct packed {
        logic  operation;
        t_word word0;
        t_word word1;
        t_word word2;
        t_word word3;
        t_word word4;
    } t_in_word;

    typedef struct packed {
        t_word out0;
        t_word out1;
        t_word out2;
        t_word out3;
        t_word out4;
    } t_out_word;

    function automatic logic [7:0] round_const(input logic [CNT_W-1:0] idx);
        logic [7:0] rc;
        unique case (idx)
            4'd0:    rc = 8'hf0;
            4'd1:    rc = 8'he1;
            4'd2:    rc = 8'hd2;
            4'd3:    rc = 8'hc3;
            4'd4:    rc = 8'hb4;
            4'd5:    rc = 8'ha5;
            4'd6:    rc = 8'h96;
            4'd7:    rc = 8'h87;
            4'd8:    rc = 8'h78;
            4'd9:    rc = 8'h69;
            4'd10:   rc = 8'h5a;
            4'd11:   rc = 8'h4b;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ascon_round.sv
`default_nettype none

module ascon_round (
    input  wire ascon_pkg::t_state i_state,
    input  wire logic [7:0]        i_rc,
    output ascon_pkg::t_state      o_state
);

    always_comb begin
        ascon_pkg::t_word x0, x1, x2, x3, x4;
        ascon_pkg::t_word y0, y1, y2, y3, y4;

        x0 = i_state[0];
        x1 = i_state[1];
        x2 = i_state[2] ^ {56'd0, i_rc};
        x3 = i_state[3];
        x4 = i_state[4];

        // Bitsliced 5-bit S-box.
        x0 = x0 ^ x4;
        x4 = x4 ^ x3;
        x2 = x2 ^ x1;
        y0 = x0 ^ (~x1 & x2);
        y1 = x1 ^ (~x2 & x3);
        y2 = x2 ^ (~x3 & x4);
        y3 = x3 ^ (~x4 & x0);
        y4 = x4 ^ (~x0 & x1);
        y1 = y1 ^ y0;
        y0 = y0 ^ y4;
        y3 = y3 ^ y2;
        y2 = ~y2;

        // Linear diffusion: each word XORed with two right rotations of itself.
        o_state[0] = y0 ^ {y0[18:0], y0[63:19]} ^ {y0[27:0], y0[63:28]};
        o_state[1] = y1 ^ {y1[60:0], y1[63:61]} ^ {y1[38:0], y1[63:39]};
        o_state[2] = y2 ^ {y2[0],    y2[63:1]}  ^ {y2[5:0],  y2[63:6]};
        o_state[3] = y3 ^ {y3[9:0],  y3[63:10]} ^ {y3[16:0], y3[63:17]};
        o_state[4] = y4 ^ {y4[6:0],  y4[63:7]}  ^ {y4[40:0], y4[63:41]};
    end

endmodule

`default_nettype wire

// File: hw/rtl/ascon_permutation_core.sv
`default_nettype none

// Ascon 320-bit permutation core, one round per clock on a shared round unit.
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one word: an
// operation bit and five 64-bit state words. Operation 0 runs ROUNDS_FULL
// rounds, operation 1 runs ROUNDS_SHORT rounds; a run of R rounds uses the
// last R of the twelve round constants.
// Output channel (o_out_valid / i_out_ready / o_out_data) returns the five
// permuted words, held in an output register until taken.
// Rounds run one after another through the single round unit. The core works
// on one word at a time and is ready again once its result is loaded into the
// output register; it accepts no new word while a run is in progress.
// If the receiver stalls, the finished state waits in the round register
// until the output register frees up, and o_in_ready stays low meanwhile.
// A synchronous reset (i_rst_n low) drops any word in flight and clears
// o_out_valid; nothing is kept between words.

module ascon_permutation_core #(
    parameter int unsigned ROUNDS_FULL  = ascon_pkg::ROUNDS_FULL,
    parameter int unsigned ROUNDS_SHORT = ascon_pkg::ROUNDS_SHORT
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_ready,
    input  wire ascon_pkg::t_in_word    i_in_data,
    output logic                        o_out_valid,
    input  wire                         i_out_ready,
    output ascon_pkg::t_out_word        o_out_data
);

    localparam logic [ascon_pkg::CNT_W-1:0] CntFull  = ascon_pkg::CNT_W'(ROUNDS_FULL);
    localparam logic [ascon_pkg::CNT_W-1:0] CntShort = ascon_pkg::CNT_W'(ROUNDS_SHORT);
    localparam logic [ascon_pkg::CNT_W-1:0] CntTop   = ascon_pkg::CNT_W'(ascon_pkg::NUM_RC);

    logic                          r_busy, n_busy;
    logic [ascon_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    ascon_pkg::t_state             r_state, n_state;
    logic                          r_out_valid, n_out_valid;
    ascon_pkg::t_out_word          r_out, n_out;

    ascon_pkg::t_state             round_out;
    logic [ascon_pkg::CNT_W-1:0]   rc_idx;
    logic                          in_accept;
    logic                          out_free;

    // Remaining round count maps straight onto the constant index.
    assign rc_idx = CntTop - r_cnt;

    ascon_round u_round (
        .i_state (r_state),
        .i_rc    (ascon_pkg::round_const(rc_idx)),
        .o_state (round_out)
    );

    assign o_in_ready = !r_busy;
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_busy      = r_busy;
        n_cnt       = r_cnt;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (in_accept) begin
            n_state = {i_in_data.word4, i_in_data.word3, i_in_data.word2,
                       i_in_data.word1, i_in_data.word0};
            n_cnt   = (i_in_data.operation == ascon_pkg::OP_SHORT) ? CntShort : CntFull;
            n_busy  = 1'b1;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                n_state = round_out;
                n_cnt   = r_cnt - 1'b1;
            end
            // The last round goes straight to the output when it is free;
            // otherwise the finished state is parked with a zero count.
            if ((r_cnt <= 1) && out_free) begin
                n_out       = (r_cnt == '0) ?
                              {r_state[0], r_state[1], r_state[2], r_state[3], r_state[4]} :
                              {round_out[0], round_out[1], round_out[2],
                               round_out[3], round_out[4]};
                n_out_valid = 1'b1;
                n_busy      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_state <= n_state;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_idle_cnt_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_cnt == '0))
        else $error("round counter nonzero while idle");

    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_busy && ((r_cnt == CntFull) || (r_cnt == CntShort))))
        else $error("accepted word did not load a round count");

    a_round_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_cnt > 1)) |=> (r_busy && (r_cnt == $past(r_cnt) - 1'b1)))
        else $error("round counter did not step");

    a_finish_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !n_busy) |=> r_out_valid)
        else $error("finished word not presented at the output");
`endif

endmodule

`default_nettype wire
